FILE: hw/rtl/fdc_pkg.sv
`default_nettype none
package fdc_pkg;

   // Geometry
   localparam int TRACKS       = 77;
   localparam int SPT          = 26;
   localparam int SECTOR_BYTES = 128;
   localparam int DRIVES       = 4;

   localparam int TRACK_LEN = SPT * SECTOR_BYTES;
   localparam int DISK_SIZE = DRIVES * TRACKS * TRACK_LEN;

   localparam int DISK_AW = $clog2(DISK_SIZE);
   localparam int BUF_AW  = $clog2(SECTOR_BYTES);
   localparam int TIDX_W  = $clog2(DRIVES * TRACKS + 1);
   localparam int LIN_W   = $clog2(DRIVES * TRACKS * SPT + 1);
   localparam int OFF_W   = $clog2(TRACK_LEN + 1);

   // Status codes
   localparam logic [7:0] ST_OK        = 8'h00;
   localparam logic [7:0] ST_TRACK0    = 8'h04;
   localparam logic [7:0] ST_BAD_CMD   = 8'h08;
   localparam logic [7:0] ST_NOT_FOUND = 8'h10;
   localparam logic [7:0] ST_NOT_READY = 8'h80;
   localparam logic [7:0] WAIT_BUSY    = 8'h80;

   // Data marks and command codes
   localparam logic [7:0] MARK_DATA  = 8'hFB;
   localparam logic [7:0] MARK_CRC   = 8'hF7;
   localparam logic [7:0] CMD_RADDR  = 8'hC4;
   localparam logic [7:0] CMD_FORCE  = 8'hD0;
   localparam logic [7:0] RADDR_LEN  = 8'd6;

   typedef enum logic [3:0] {
      FN_STAT_RD = 4'd0,
      FN_CMD_WR  = 4'd1,
      FN_TRK_RD  = 4'd2,
      FN_TRK_WR  = 4'd3,
      FN_SEC_RD  = 4'd4,
      FN_SEC_WR  = 4'd5,
      FN_DATA_RD = 4'd6,
      FN_DATA_WR = 4'd7,
      FN_WAIT_RD = 4'd8,
      FN_EXT_WR  = 4'd9
   } func_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_READ   = 3'd1,
      MODE_WRITE  = 3'd2,
      MODE_RADDR  = 3'd3,
      MODE_FORMAT = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WAIT1,
      S_WAIT2,
      S_EXEC,
      S_READ,
      S_COPY
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load;
      logic exec;
      logic mem_out;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic disk_rd;
      logic copy_start;
      logic copy_busy;
   } dp_stat_type;

endpackage
`default_nettype wire

FILE: hw/rtl/fdc_ctrl.sv
`default_nettype none
module fdc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output fdc_pkg::dp_cmd_type  cmd,
   input  fdc_pkg::dp_stat_type stat
);
   import fdc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_set;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == S_IDLE);

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      rsp_set  = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_WAIT1;
            end
         end
         S_WAIT1: state_in = S_WAIT2;
         S_WAIT2: begin
            // address pipeline has settled; wait for room at the output
            if (out_free) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.disk_rd) begin
               state_in = S_READ;
            end else begin
               rsp_set  = 1'b1;
               state_in = stat.copy_start ? S_COPY : S_IDLE;
            end
         end
         S_READ: begin
            cmd.mem_out = 1'b1;
            rsp_set     = 1'b1;
            state_in    = S_IDLE;
         end
         S_COPY: begin
            if (!stat.copy_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_set || (rsp_valid_ff && !rsp_tready);
   end

endmodule
`default_nettype wire

FILE: hw/rtl/fdc_datapath.sv
`default_nettype none
module fdc_datapath (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [15:0]          req_tdata,
   output logic [7:0]           rsp_tdata,
   input  wire                  csr_wr_en,
   input  wire  [3:0]           csr_wr_data,
   input  fdc_pkg::dp_cmd_type  cmd,
   output fdc_pkg::dp_stat_type stat
);
   import fdc_pkg::*;

   // Memories
   logic [7:0] buf_mem [SECTOR_BYTES];
   logic [7:0] disk_mem [DISK_SIZE];

   // Latched word
   logic [3:0] func_ff;
   logic [7:0] wdata_ff;

   // Controller registers
   logic [7:0]         status_ff, status_in;
   logic [7:0]         track_ff, track_in;
   logic [7:0]         sector_ff, sector_in;
   logic [1:0]         drive_ff, drive_in;
   mode_type           mode_ff, mode_in;
   logic [7:0]         idx_ff, idx_in;
   logic [1:0]         fphase_ff, fphase_in;
   logic [7:0]         fbytes_ff, fbytes_in;
   logic [4:0]         fdone_ff, fdone_in;
   logic [OFF_W-1:0]   foff_ff, foff_in;
   logic [DISK_AW-1:0] latched_ff, latched_in;
   logic [7:0]         rsec_ff, rsec_in;
   logic [3:0]         mask_ff;
   logic [7:0]         rdata_ff;

   // Address pipeline
   logic [TIDX_W-1:0]  t_ff;
   logic [LIN_W-1:0]   lin_ff;
   logic [DISK_AW-1:0] fbase_ff, sbase_ff;

   // Copy engine
   logic [7:0]         cp_left_ff;
   logic [7:0]         cp_src_ff;
   logic [DISK_AW-1:0] cp_dst_ff, cp_wa_ff;
   logic               cp_v_ff;
   logic [7:0]         buf_q_ff;

   // Clearing pass and disk read
   logic [DISK_AW-1:0] clr_cnt_ff;
   logic [7:0]         disk_q_ff;

   // Execute outputs
   logic [7:0]         r;
   logic               disk_rd;
   logic [DISK_AW-1:0] disk_ra;
   logic               buf_we;
   logic [BUF_AW-1:0]  buf_wa;
   logic               copy_start;
   logic [DISK_AW-1:0] copy_dst;
   logic [7:0]         copy_len;

   logic               drive_ok, sec_bad;
   logic [7:0]         trk_step;
   logic [OFF_W:0]     room;
   logic [DISK_AW-1:0] rd_base;

   assign rsp_tdata = rdata_ff;

   assign drive_ok = (32'(drive_ff) < DRIVES) && mask_ff[drive_ff];
   assign sec_bad  = (32'(track_ff) >= TRACKS) || (sector_ff == 8'd0) ||
                     (32'(sector_ff) > SPT);
   assign room     = (OFF_W+1)'(TRACK_LEN) - {1'b0, foff_ff};

   assign stat.clear_last = (clr_cnt_ff == DISK_AW'(DISK_SIZE - 1));
   assign stat.disk_rd    = disk_rd;
   assign stat.copy_start = copy_start;
   assign stat.copy_busy  = (cp_left_ff != 8'd0) || cp_v_ff;

   // Execute one port access
   always_comb begin
      status_in  = status_ff;
      track_in   = track_ff;
      sector_in  = sector_ff;
      drive_in   = drive_ff;
      mode_in    = mode_ff;
      idx_in     = idx_ff;
      fphase_in  = fphase_ff;
      fbytes_in  = fbytes_ff;
      fdone_in   = fdone_ff;
      foff_in    = foff_ff;
      latched_in = latched_ff;
      rsec_in    = rsec_ff;
      r          = 8'd0;
      disk_rd    = 1'b0;
      buf_we     = 1'b0;
      buf_wa     = idx_ff[BUF_AW-1:0];
      copy_start = 1'b0;
      copy_dst   = latched_ff;
      copy_len   = 8'(SECTOR_BYTES);
      trk_step   = track_ff;
      rd_base    = (idx_ff == 8'd0) ? sbase_ff : latched_ff;
      disk_ra    = rd_base + DISK_AW'(idx_ff);

      case (func_ff)
         FN_STAT_RD: r = status_ff;
         FN_CMD_WR: begin
            unique case (wdata_ff) inside
               [8'h00:8'h0F]: begin
                  track_in  = 8'd0;
                  status_in = ST_TRACK0;
               end
               [8'h10:8'h1F]: begin
                  status_in = (32'(track_ff) <= TRACKS) ? ST_OK : ST_NOT_FOUND;
               end
               [8'h40:8'h7F]: begin
                  // step in / step out, track updated only with bit 4
                  if (wdata_ff[4])
                     trk_step = wdata_ff[5] ? track_ff - 8'd1 : track_ff + 8'd1;
                  track_in  = trk_step;
                  status_in = (32'(trk_step) <= TRACKS) ? ST_OK : ST_NOT_FOUND;
               end
               [8'h80:8'h8F], [8'hA0:8'hAF], CMD_RADDR, [8'hF0:8'hFF]: begin
                  if (wdata_ff[7:4] == 4'h8)      mode_in = MODE_READ;
                  else if (wdata_ff[7:4] == 4'hA) mode_in = MODE_WRITE;
                  else if (wdata_ff[7:4] == 4'hF) mode_in = MODE_FORMAT;
                  else                            mode_in = MODE_RADDR;
                  idx_in    = 8'd0;
                  fphase_in = 2'd0;
                  status_in = ST_OK;
               end
               [8'h90:8'h9F], [8'hB0:8'hBF], [8'hE0:8'hEF]: status_in = ST_NOT_FOUND;
               [CMD_FORCE:8'hDF]: begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_OK;
               end
               default: status_in = ST_BAD_CMD;
            endcase
         end
         FN_TRK_RD: r = track_ff;
         FN_TRK_WR: track_in = wdata_ff;
         FN_SEC_RD: r = sector_ff;
         FN_SEC_WR: sector_in = wdata_ff;
         FN_DATA_RD: begin
            if (mode_ff == MODE_READ) begin
               if (idx_ff == 8'd0 && sec_bad) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_NOT_FOUND;
               end else if (idx_ff == 8'd0 && !drive_ok) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_NOT_READY;
               end else if (32'(idx_ff) >= SECTOR_BYTES) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_OK;
               end else begin
                  if (32'(idx_ff) == SECTOR_BYTES - 1) begin
                     mode_in   = MODE_IDLE;
                     status_in = ST_OK;
                  end
                  latched_in = rd_base;
                  disk_rd    = 1'b1;
                  idx_in     = idx_ff + 8'd1;
               end
            end else if (mode_ff == MODE_RADDR) begin
               if (idx_ff >= RADDR_LEN) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_OK;
               end else begin
                  if (idx_ff == RADDR_LEN - 8'd1) begin
                     mode_in   = MODE_IDLE;
                     status_in = ST_OK;
                  end
                  if (idx_ff == 8'd0) begin
                     rsec_in = sector_ff;
                     r       = track_ff;
                  end else if (idx_ff == 8'd2) begin
                     r = rsec_ff;
                  end
                  idx_in = idx_ff + 8'd1;
               end
            end
         end
         FN_DATA_WR: begin
            if (mode_ff == MODE_WRITE) begin
               if (idx_ff == 8'd0 && sec_bad) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_NOT_FOUND;
               end else if (idx_ff == 8'd0 && !drive_ok) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_NOT_READY;
               end else begin
                  if (idx_ff == 8'd0) latched_in = sbase_ff;
                  if (32'(idx_ff) < SECTOR_BYTES) begin
                     buf_we = 1'b1;
                     idx_in = idx_ff + 8'd1;
                  end
                  // buffer full: commit the sector
                  if (32'(idx_in) >= SECTOR_BYTES) begin
                     mode_in    = MODE_IDLE;
                     status_in  = ST_OK;
                     copy_start = 1'b1;
                     copy_dst   = latched_in;
                  end
               end
            end else if (mode_ff == MODE_FORMAT) begin
               buf_wa = fbytes_ff[BUF_AW-1:0];
               if (fphase_ff == 2'd0 && !drive_ok) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_NOT_READY;
               end else if (fphase_ff == 2'd0 && 32'(track_ff) >= TRACKS) begin
                  mode_in   = MODE_IDLE;
                  status_in = ST_NOT_FOUND;
               end else if (fphase_ff != 2'd2) begin
                  if (fphase_ff == 2'd0) begin
                     latched_in = fbase_ff;
                     fdone_in   = 5'd0;
                     foff_in    = '0;
                  end
                  fphase_in = 2'd1;
                  if (wdata_ff == MARK_DATA) begin
                     fphase_in = 2'd2;
                     fbytes_in = 8'd0;
                  end
               end else if (wdata_ff != MARK_CRC) begin
                  if (32'(fbytes_ff) < SECTOR_BYTES) begin
                     buf_we    = 1'b1;
                     fbytes_in = fbytes_ff + 8'd1;
                  end
               end else begin
                  // flush the collected sector into the track
                  copy_len   = ({1'b0, 8'd0} + (OFF_W+1)'(fbytes_ff) < room) ?
                               fbytes_ff : 8'(room);
                  copy_start = 1'b1;
                  copy_dst   = latched_ff + DISK_AW'(foff_ff);
                  foff_in    = foff_ff + OFF_W'(copy_len);
                  fdone_in   = fdone_ff + 5'd1;
                  fphase_in  = 2'd1;
                  if (32'(fdone_in) == SPT) begin
                     mode_in   = MODE_IDLE;
                     status_in = ST_OK;
                  end
               end
            end else begin
               track_in = wdata_ff;
            end
         end
         FN_WAIT_RD: r = (mode_ff == MODE_IDLE) ? 8'd0 : WAIT_BUSY;
         FN_EXT_WR:  drive_in = ~wdata_ff[5:4];
         default: r = 8'd0;
      endcase
   end

   // Register file, word latch and address pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= 8'd0;
         track_ff   <= 8'd0;
         sector_ff  <= 8'd0;
         drive_ff   <= 2'd0;
         mode_ff    <= MODE_IDLE;
         idx_ff     <= 8'd0;
         fphase_ff  <= 2'd0;
         fbytes_ff  <= 8'd0;
         fdone_ff   <= 5'd0;
         foff_ff    <= '0;
         latched_ff <= '0;
         mask_ff    <= 4'hF;
      end else begin
         if (cmd.exec) begin
            status_ff  <= status_in;
            track_ff   <= track_in;
            sector_ff  <= sector_in;
            drive_ff   <= drive_in;
            mode_ff    <= mode_in;
            idx_ff     <= idx_in;
            fphase_ff  <= fphase_in;
            fbytes_ff  <= fbytes_in;
            fdone_ff   <= fdone_in;
            foff_ff    <= foff_in;
            latched_ff <= latched_in;
         end
         if (csr_wr_en) mask_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_tdata[3:0];
         wdata_ff <= req_tdata[11:4];
      end
      if (cmd.exec) begin
         rsec_ff  <= rsec_in;
         rdata_ff <= r;
      end else if (cmd.mem_out) begin
         rdata_ff <= disk_q_ff;
      end
      t_ff     <= TIDX_W'(32'(drive_ff) * TRACKS + 32'(track_ff));
      lin_ff   <= LIN_W'(32'(t_ff) * SPT + 32'(sector_ff) - 1);
      fbase_ff <= DISK_AW'(32'(t_ff) * TRACK_LEN);
      sbase_ff <= DISK_AW'(32'(lin_ff) * SECTOR_BYTES);
   end

   // Copy engine control: buffer to disk, one byte a cycle; clearing-pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cp_left_ff <= 8'd0;
         cp_v_ff    <= 1'b0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.exec && copy_start) begin
            cp_left_ff <= copy_len;
            cp_src_ff  <= 8'd0;
            cp_dst_ff  <= copy_dst;
         end else if (cp_left_ff != 8'd0) begin
            cp_left_ff <= cp_left_ff - 8'd1;
            cp_src_ff  <= cp_src_ff + 8'd1;
            cp_dst_ff  <= cp_dst_ff + DISK_AW'(1);
         end
         cp_v_ff <= (cp_left_ff != 8'd0) && !(cmd.exec && copy_start);
         if (cmd.clear_step) clr_cnt_ff <= clr_cnt_ff + DISK_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      cp_wa_ff <= cp_dst_ff;
   end

   // Sector buffer
   always_ff @(posedge clock) begin
      if (cmd.exec && buf_we) buf_mem[buf_wa] <= wdata_ff;
      buf_q_ff <= buf_mem[cp_src_ff[BUF_AW-1:0]];
   end

   // Disk store: clearing pass or copy write, execute-time read
   always_ff @(posedge clock) begin
      if (cmd.clear_step)  disk_mem[clr_cnt_ff] <= 8'd0;
      else if (cp_v_ff)    disk_mem[cp_wa_ff]   <= buf_q_ff;
      if (cmd.exec && disk_rd) disk_q_ff <= disk_mem[disk_ra];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/floppy_controller_sector_io.sv
// A word is latched when accepted and passes two address stages, the second one
// also waiting for room at the output, before it executes and its result is
// registered; a sector data read adds a state for the disk store port. A new word
// is accepted only after the last one has executed; a sector commit or format
// flush then holds the input while the bytes are copied, one byte a cycle.
// Reset: synchronous; clears the control and status registers, then zeroes all
// 1,025,024 bytes of the disk store, one byte a cycle, before accepting a word.
`default_nettype none
module floppy_controller_sector_io (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [3:0] func, [11:4] wdata, [15:12] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] rdata
   input  wire         csr_wr_en,
   input  wire  [3:0]  csr_wr_data  // drive_ready_mask
);
   import fdc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   fdc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import fdc_pkg::*;

   typedef struct {
      logic [3:0] fn;
      logic [7:0] wd;
   } port_access_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en;
   logic [3:0]  csr_wr_data;

   floppy_controller_sector_io i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Controller shadow state
   bit [7:0]  disk_img [0:DISK_SIZE-1];
   bit [7:0]  sec_buf [0:SECTOR_BYTES-1];
   logic [7:0] st_reg, trk_reg, sec_reg;
   logic [1:0] drv_sel;
   logic [3:0] ready_mask;
   mode_type   mode;
   logic [7:0] bidx, fmt_bytes;
   logic [1:0] fmt_phase;
   logic [4:0] fmt_done;
   int         fmt_off, wr_base;

   port_access_type pending_words[$];
   logic [7:0]   expected_rdata[$];
   int           n_errors = 0;
   int           n_results = 0;
   int           n_put = 0;
   int           send_gap = 0;
   int           recv_stall = 0;
   bit           no_idle = 0;

   function automatic bit drive_ready();
      return ready_mask[drv_sel];
   endfunction

   function automatic bit addr_bad();
      return trk_reg >= TRACKS || sec_reg == 0 || sec_reg > SPT;
   endfunction

   function automatic int sec_base();
      return ((int'(drv_sel) * TRACKS + int'(trk_reg)) * SPT + int'(sec_reg) - 1)
             * SECTOR_BYTES;
   endfunction

   function automatic void go_idle(logic [7:0] s);
      mode   = MODE_IDLE;
      st_reg = s;
   endfunction

   function automatic void seek_done();
      st_reg = (trk_reg <= TRACKS) ? ST_OK : ST_NOT_FOUND;
   endfunction

   function automatic void run_command(logic [7:0] c);
      logic [7:0] hi;
      hi = c & 8'hF0;
      if (hi == 8'h00) begin
         trk_reg = 0;
         st_reg  = ST_TRACK0;
      end else if (hi == 8'h10) begin
         seek_done();
      end else if (c[7:5] == 3'b010) begin
         if (c[4]) trk_reg = trk_reg + 8'd1;
         seek_done();
      end else if (c[7:5] == 3'b011) begin
         if (c[4]) trk_reg = trk_reg - 8'd1;
         seek_done();
      end else if (hi == 8'h80 || hi == 8'hA0 || hi == 8'hF0 || c == CMD_RADDR) begin
         mode = (hi == 8'h80) ? MODE_READ : (hi == 8'hA0) ? MODE_WRITE :
                (hi == 8'hF0) ? MODE_FORMAT : MODE_RADDR;
         bidx      = 0;
         fmt_phase = 0;
         st_reg    = ST_OK;
      end else if (hi == 8'h90 || hi == 8'hB0 || hi == 8'hE0) begin
         st_reg = ST_NOT_FOUND;
      end else if (hi == (CMD_FORCE & 8'hF0)) begin
         go_idle(ST_OK);
      end else begin
         st_reg = ST_BAD_CMD;
      end
   endfunction

   function automatic logic [7:0] data_rd();
      logic [7:0] v;
      if (mode == MODE_READ) begin
         if (bidx == 0) begin
            if (addr_bad()) begin go_idle(ST_NOT_FOUND); return 0; end
            if (!drive_ready()) begin go_idle(ST_NOT_READY); return 0; end
            for (int i = 0; i < SECTOR_BYTES; i++) sec_buf[i] = disk_img[sec_base() + i];
         end
         if (bidx >= SECTOR_BYTES) begin go_idle(ST_OK); return 0; end
         if (bidx == SECTOR_BYTES - 1) go_idle(ST_OK);
         v = sec_buf[bidx];
         bidx++;
         return v;
      end
      if (mode == MODE_RADDR) begin
         if (bidx == 0) begin
            for (int i = 0; i < RADDR_LEN; i++) sec_buf[i] = 0;
            sec_buf[0] = trk_reg;
            sec_buf[2] = sec_reg;
         end
         if (bidx >= RADDR_LEN) begin go_idle(ST_OK); return 0; end
         if (bidx == RADDR_LEN - 1) go_idle(ST_OK);
         v = sec_buf[bidx];
         bidx++;
         return v;
      end
      return 0;
   endfunction

   function automatic void format_wr(logic [7:0] d);
      if (fmt_phase == 0) begin
         if (!drive_ready()) begin go_idle(ST_NOT_READY); return; end
         if (trk_reg >= TRACKS) begin go_idle(ST_NOT_FOUND); return; end
         wr_base   = (int'(drv_sel) * TRACKS + int'(trk_reg)) * TRACK_LEN;
         fmt_phase = 1;
         fmt_done  = 0;
         fmt_off   = 0;
      end
      if (fmt_phase == 1) begin
         if (d == MARK_DATA) begin
            fmt_phase = 2;
            fmt_bytes = 0;
         end
         return;
      end
      if (d != MARK_CRC) begin
         if (fmt_bytes < SECTOR_BYTES) begin
            sec_buf[fmt_bytes] = d;
            fmt_bytes++;
         end
         return;
      end
      // end of sector: flush collected bytes into the track
      for (int i = 0; i < fmt_bytes; i++) begin
         if (fmt_off < TRACK_LEN) begin
            disk_img[wr_base + fmt_off] = sec_buf[i];
            fmt_off++;
         end
      end
      fmt_done++;
      fmt_phase = 1;
      if (fmt_done == SPT) go_idle(ST_OK);
   endfunction

   function automatic void data_wr(logic [7:0] d);
      if (mode == MODE_WRITE) begin
         if (bidx == 0) begin
            if (addr_bad()) begin go_idle(ST_NOT_FOUND); return; end
            if (!drive_ready()) begin go_idle(ST_NOT_READY); return; end
            wr_base = sec_base();
         end
         if (bidx < SECTOR_BYTES) begin
            sec_buf[bidx] = d;
            bidx++;
         end
         if (bidx >= SECTOR_BYTES) begin
            go_idle(ST_OK);
            for (int i = 0; i < SECTOR_BYTES; i++) disk_img[wr_base + i] = sec_buf[i];
         end
      end else if (mode == MODE_FORMAT) begin
         format_wr(d);
      end else begin
         trk_reg = d;
      end
   endfunction

   // Expected read data for one port access, updating the shadow state
   function automatic logic [7:0] port_access(logic [3:0] fn, logic [7:0] wd);
      logic [7:0] r;
      r = 0;
      case (fn)
         FN_STAT_RD: r = st_reg;
         FN_CMD_WR:  run_command(wd);
         FN_TRK_RD:  r = trk_reg;
         FN_TRK_WR:  trk_reg = wd;
         FN_SEC_RD:  r = sec_reg;
         FN_SEC_WR:  sec_reg = wd;
         FN_DATA_RD: r = data_rd();
         FN_DATA_WR: data_wr(wd);
         FN_WAIT_RD: r = (mode == MODE_IDLE) ? 8'h00 : WAIT_BUSY;
         FN_EXT_WR:  drv_sel = ~wd[5:4];
         default:    r = 0;
      endcase
      return r;
   endfunction

   // Clock and reset
   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;
   end

   // Driver: feeds queued words, predicts each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_rdata.push_back(port_access(req_tdata[3:0], req_tdata[11:4]));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 0;
            end else if (pending_words.size() > 0) begin
               port_access_type w;
               w = pending_words.pop_front();
               req_tdata  <= {4'b0, w.wd, w.fn};
               req_tvalid <= 1;
               send_gap = no_idle ? 0 : $urandom_range(0, 5);
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // Monitor: checks every result word against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rdata.size() == 0) begin
               $error("unexpected result word: rdata %0h", rsp_tdata);
               n_errors++;
            end else begin
               logic [7:0] e;
               e = expected_rdata.pop_front();
               if (rsp_tdata !== e) begin
                  $error("rdata mismatch: expected %0h actual %0h", e, rsp_tdata);
                  n_errors++;
               end
            end
            n_results++;
            recv_stall = no_idle ? 0 : $urandom_range(0, 5);
            // one long hold-off so the block backs up into its input
            if (n_results == 300) recv_stall = 400;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   task automatic put(logic [3:0] fn, logic [7:0] wd);
      port_access_type w;
      w.fn = fn;
      w.wd = wd;
      pending_words.push_back(w);
      n_put++;
   endtask

   task automatic select_drive(logic [1:0] d);
      logic [7:0] wd;
      wd = 8'($urandom);
      wd[5:4] = ~d;
      put(FN_EXT_WR, wd);
   endtask

   task automatic seek_to(logic [1:0] d, logic [7:0] t, logic [7:0] s);
      select_drive(d);
      put(FN_TRK_WR, t);
      put(FN_SEC_WR, s);
   endtask

   // sampled between edges, once the driver's updates have settled
   task automatic drain_all();
      while (pending_words.size() > 0 || req_tvalid || expected_rdata.size() > 0)
         @(negedge clock);
   endtask

   task automatic set_mask(logic [3:0] m);
      drain_all();
      // a sector commit may still be copying after its result
      repeat (300) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= m;
      ready_mask = m;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [7:0] pick_track();
      case ($urandom_range(0, 9))
         0:       return 8'(TRACKS - 1);
         1:       return 8'(TRACKS);
         2:       return 8'hFF;
         default: return 8'($urandom_range(0, 2));
      endcase
   endfunction

   function automatic logic [7:0] pick_sector();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 8'(SPT + 1);
         2:       return 8'(SPT);
         default: return 8'($urandom_range(1, 3));
      endcase
   endfunction

   // One random sequence: mostly well-formed transfers, some noise
   task automatic random_sequence();
      int kind, n;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 2) == 0) put(FN_CMD_WR, 8'($urandom));
            else put(4'($urandom_range(0, 15)), 8'($urandom));
         end
      end else if (kind < 52) begin
         seek_to(2'($urandom), pick_track(), pick_sector());
         put(FN_CMD_WR, 8'hA0 | 8'($urandom_range(0, 15)));
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : SECTOR_BYTES;
         repeat (n) put(FN_DATA_WR, 8'($urandom));
         if (n < SECTOR_BYTES) put(FN_CMD_WR, CMD_FORCE | 8'($urandom_range(0, 15)));
         put(FN_STAT_RD, 8'($urandom));
      end else if (kind < 74) begin
         seek_to(2'($urandom), pick_track(), pick_sector());
         put(FN_CMD_WR, 8'h80 | 8'($urandom_range(0, 15)));
         repeat (SECTOR_BYTES + $urandom_range(0, 2)) put(FN_DATA_RD, 8'($urandom));
         put(FN_WAIT_RD, 8'($urandom));
         put(FN_STAT_RD, 8'($urandom));
      end else if (kind < 88) begin
         seek_to(2'($urandom), 8'($urandom), 8'($urandom));
         put(FN_CMD_WR, CMD_RADDR);
         repeat ($urandom_range(3, 8)) put(FN_DATA_RD, 8'($urandom));
         put(FN_WAIT_RD, 8'($urandom));
      end else begin
         seek_to(2'($urandom), pick_track(), 1);
         put(FN_CMD_WR, 8'hF0 | 8'($urandom_range(0, 15)));
         repeat ($urandom_range(0, 3)) put(FN_DATA_WR, 8'($urandom_range(0, 8'hF0)));
         for (int s = 0; s < SPT; s++) begin
            put(FN_DATA_WR, MARK_DATA);
            n = (s == 0 && $urandom_range(0, 3) == 0) ? SECTOR_BYTES + 3
                                                     : $urandom_range(0, 3);
            repeat (n) put(FN_DATA_WR, 8'($urandom_range(0, 8'hF6)));
            put(FN_DATA_WR, MARK_CRC);
         end
         put(FN_STAT_RD, 8'($urandom));
         put(FN_CMD_WR, 8'h80);
         repeat (SECTOR_BYTES) put(FN_DATA_RD, 8'($urandom));
      end
   endtask

   // Stimulus
   initial begin
      logic [3:0] masks[5];
      csr_wr_en   = 0;
      csr_wr_data = 0;
      st_reg = 0; trk_reg = 0; sec_reg = 0; drv_sel = 0;
      mode = MODE_IDLE; bidx = 0; fmt_bytes = 0; fmt_phase = 0; fmt_done = 0;
      fmt_off = 0; wr_base = 0; ready_mask = 4'hF;
      masks = '{4'hF, 4'h0, 4'h5, 4'hA, 4'hF};
      @(negedge reset);

      // directed: register extremes, command classes, odd ports
      select_drive(0);
      put(FN_STAT_RD, 8'h00);
      put(FN_TRK_WR, 8'hFF);
      put(FN_TRK_RD, 8'hFF);
      put(FN_SEC_WR, 8'h00);
      put(FN_SEC_RD, 8'h00);
      put(FN_CMD_WR, 8'h0F);
      put(FN_CMD_WR, 8'h7F);
      put(FN_STAT_RD, 8'hFF);
      put(FN_CMD_WR, 8'h5F);
      put(FN_CMD_WR, 8'h1F);
      put(FN_CMD_WR, 8'h2A);
      put(FN_STAT_RD, 8'h00);
      put(FN_CMD_WR, 8'h9F);
      put(FN_CMD_WR, 8'hC0);
      put(FN_WAIT_RD, 8'h00);
      put(FN_DATA_WR, 8'hAA);
      put(FN_DATA_RD, 8'h00);
      put(4'hF, 8'hFF);
      put(4'hA, 8'h55);
      put(FN_CMD_WR, 8'h80);
      put(FN_WAIT_RD, 8'h00);
      put(FN_DATA_RD, 8'h00);
      put(FN_STAT_RD, 8'h00);

      foreach (masks[p]) begin
         set_mask(masks[p]);
         no_idle = (p == 2);
         while (n_put < 275 * (p + 1)) begin
            random_sequence();
            // keep the queue short so phases interleave with the block
            while (pending_words.size() > 200) @(posedge clock);
         end
         if (p == 1) begin
            // long pause on the input side until all results are back
            drain_all();
            put(FN_STAT_RD, 8'h00);
         end
      end

      drain_all();
      repeat (50) @(posedge clock);
      if (n_errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
